// ===== rtl/integer_to_ascii_radix_core_defines.svh =====
// Assertion macros for the integer to ASCII radix converter.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ITOAR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define ITOAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/itoar_pkg.sv =====
// Shared types, constants and the digit encoding of the radix converter.
// No dependencies.
package itoar_pkg;

  localparam int WORD_BITS      = 32;
  localparam int VALUE_W        = 32;
  localparam int BASE_W         = 6;
  localparam int CHAR_W         = 7;
  // Quotient bits retired per division cycle.
  localparam int DIV_BITS       = 4;
  localparam int DIV_CYCLES     = WORD_BITS / DIV_BITS;
  localparam int STEP_W         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int STACK_DEPTH    = WORD_BITS;
  localparam int IDX_W          = $clog2(STACK_DEPTH);
  localparam int CNT_W          = $clog2(STACK_DEPTH + 1);

  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER   = 7'h37;  // 'A' minus ten
  localparam logic [CHAR_W-1:0] CHAR_MINUS    = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NONE     = 7'h00;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [BASE_W-1:0]  base;
    logic               signed_mode;
  } itoar_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
    logic              bad_base;
  } itoar_res_t;

  typedef struct packed {
    logic load;
    logic emit_bad;
    logic div_step;
    logic push_digit;
    logic push_minus;
    logic pop;
  } itoar_cmd_t;

  typedef struct packed {
    logic base_bad;
    logic neg;
    logic div_done;
    logic quot_zero;
    logic last_char;
  } itoar_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < BASE_DEC) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_LETTER + dx;
  endfunction

endpackage

// ===== rtl/integer_to_ascii_radix_core.sv =====
// Top level of the integer to ASCII radix converter.
// Depends on itoar_pkg, itoar_ctrl, itoar_dp and integer_to_ascii_radix_core_defines.svh.
//
// A request is taken when start is high and busy is low. Its text leaves most significant
// character first, one character per cycle on out_res while out_valid is high, with last
// set on the final one; the receiver cannot stall, so characters must be captured as they
// appear. Each digit costs one division of the word by the base in a shared shift-subtract
// unit retiring four quotient bits a cycle, followed by a step that stacks the digit; a
// minus sign is stacked after the digits for a negative value in signed decimal mode, so
// it leaves first. A bad base is answered by a single error result in the cycle after the
// request, without raising busy.
`include "integer_to_ascii_radix_core_defines.svh"

module integer_to_ascii_radix_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  itoar_pkg::itoar_req_t in_req,
  output logic                  out_valid,
  output itoar_pkg::itoar_res_t out_res
);

  itoar_pkg::itoar_cmd_t  cmd;
  itoar_pkg::itoar_stat_t stat;

  itoar_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  itoar_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  `ITOAR_ASSERT_NEXT(a_bad_base_answered, start && !busy && stat.base_bad,
                     out_valid && out_res.bad_base && out_res.last,
                     "bad base request not answered by an error result")
  `ITOAR_ASSERT_SAME(a_bad_result_form, out_valid && out_res.bad_base,
                     out_res.last && (out_res.char_out == itoar_pkg::CHAR_NONE),
                     "malformed error result")
  `ITOAR_ASSERT_NEXT(a_load_sets_busy, cmd.load, busy, "accepted request did not raise busy")
  `ITOAR_ASSERT_NEXT(a_text_unbroken, out_valid && !out_res.last,
                     out_valid && !out_res.bad_base, "character stream broken before last")

endmodule

// ===== rtl/itoar_dp.sv =====
// Datapath of the radix converter: shift-subtract divider, digit stack, result register.
// Depends on itoar_pkg.
module itoar_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itoar_pkg::itoar_req_t  in_req,
  input  itoar_pkg::itoar_cmd_t  cmd,
  output itoar_pkg::itoar_stat_t stat,
  output logic                 out_valid,
  output itoar_pkg::itoar_res_t  out_res
);

  logic [itoar_pkg::WORD_BITS-1:0] work_r, work_nxt;
  logic [itoar_pkg::BASE_W-1:0]    rem_r, rem_nxt;
  logic [itoar_pkg::BASE_W-1:0]    base_r;
  logic                            neg_r;
  logic [itoar_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [itoar_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [itoar_pkg::CHAR_W-1:0]    stack_r [itoar_pkg::STACK_DEPTH];
  logic                            out_valid_r, out_valid_nxt;
  itoar_pkg::itoar_res_t           out_res_r, out_res_nxt;

  logic [itoar_pkg::WORD_BITS-1:0] in_word;
  logic                            in_neg;
  logic [itoar_pkg::WORD_BITS-1:0] in_mag;
  logic [itoar_pkg::WORD_BITS-1:0] div_work;
  logic [itoar_pkg::BASE_W-1:0]    div_rem;
  logic [itoar_pkg::CNT_W-1:0]     cnt_dec;
  logic [itoar_pkg::IDX_W-1:0]     push_idx, pop_idx;
  logic                            push_en;
  logic [itoar_pkg::CHAR_W-1:0]    push_char;

  assign in_word = in_req.value[itoar_pkg::WORD_BITS-1:0];
  assign in_neg  = in_req.signed_mode && (in_req.base == itoar_pkg::BASE_DEC) &&
                   in_word[itoar_pkg::WORD_BITS-1];
  assign in_mag  = in_neg ? (~in_word) + itoar_pkg::WORD_BITS'(1) : in_word;

  // Several restoring division steps per cycle; the remainder stays below the base.
  always_comb begin
    logic [itoar_pkg::WORD_BITS-1:0] w;
    logic [itoar_pkg::BASE_W:0]      r;
    logic                            q;
    w = work_r;
    r = {1'b0, rem_r};
    for (int i = 0; i < itoar_pkg::DIV_BITS; i++) begin
      r = {r[itoar_pkg::BASE_W-1:0], w[itoar_pkg::WORD_BITS-1]};
      q = (r >= {1'b0, base_r});
      if (q) begin
        r = r - {1'b0, base_r};
      end
      w = {w[itoar_pkg::WORD_BITS-2:0], q};
    end
    div_work = w;
    div_rem  = r[itoar_pkg::BASE_W-1:0];
  end

  assign cnt_dec  = cnt_r - itoar_pkg::CNT_W'(1);
  assign push_idx = cnt_r[itoar_pkg::IDX_W-1:0];
  assign pop_idx  = cnt_dec[itoar_pkg::IDX_W-1:0];
  assign push_en  = cmd.push_digit || cmd.push_minus;
  assign push_char = cmd.push_minus ? itoar_pkg::CHAR_MINUS : itoar_pkg::digit_char(rem_r);

  always_comb begin
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    if (cmd.load) begin
      work_nxt = in_mag;
      rem_nxt  = '0;
      step_nxt = '0;
      cnt_nxt  = '0;
    end
    if (cmd.div_step) begin
      work_nxt = div_work;
      rem_nxt  = div_rem;
      step_nxt = (step_r == itoar_pkg::STEP_W'(itoar_pkg::DIV_CYCLES - 1)) ?
                 '0 : step_r + itoar_pkg::STEP_W'(1);
    end
    if (cmd.push_digit) begin
      rem_nxt = '0;
    end
    if (push_en) begin
      cnt_nxt = cnt_r + itoar_pkg::CNT_W'(1);
    end
    if (cmd.pop) begin
      cnt_nxt       = cnt_dec;
      out_valid_nxt = 1'b1;
      out_res_nxt   = '{char_out: stack_r[pop_idx],
                        last: (cnt_r == itoar_pkg::CNT_W'(1)), bad_base: 1'b0};
    end
    if (cmd.emit_bad) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = '{char_out: itoar_pkg::CHAR_NONE, last: 1'b1, bad_base: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r    <= work_nxt;
    rem_r     <= rem_nxt;
    out_res_r <= out_res_nxt;
    if (cmd.load) begin
      base_r <= in_req.base;
      neg_r  <= in_neg;
    end
    if (push_en) begin
      stack_r[push_idx] <= push_char;
    end
  end

  assign stat.base_bad  = (in_req.base < itoar_pkg::BASE_MIN) ||
                          (in_req.base > itoar_pkg::BASE_MAX);
  assign stat.neg       = neg_r;
  assign stat.div_done  = (step_r == itoar_pkg::STEP_W'(itoar_pkg::DIV_CYCLES - 1));
  assign stat.quot_zero = (work_r == '0);
  assign stat.last_char = (cnt_r == itoar_pkg::CNT_W'(1));

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/itoar_ctrl.sv =====
// Controller of the radix converter: sequences division, digit pushes and character output.
// Depends on itoar_pkg.
module itoar_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  itoar_pkg::itoar_stat_t stat,
  output itoar_pkg::itoar_cmd_t  cmd,
  output logic                   busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_PUSH  = 5'b00100,
    S_MINUS = 5'b01000,
    S_EMIT  = 5'b10000
  } itoar_state_t;

  itoar_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        // A bad base is answered straight from idle with a single error result.
        if (start) begin
          if (stat.base_bad) begin
            cmd.emit_bad = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push_digit = 1'b1;
        if (!stat.quot_zero) begin
          state_nxt = S_DIV;
        end else if (stat.neg) begin
          state_nxt = S_MINUS;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MINUS: begin
        cmd.push_minus = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        cmd.pop = 1'b1;
        if (stat.last_char) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
